FILE: rtl/ihss_pkg.sv
`default_nettype none
package ihss_pkg;

    localparam int POSITION_BITS = 24;
    localparam int LENGTH_BITS   = 24;
    localparam int CMP_BITS      = ((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS)
                                   + 2;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0]   LIMIT_MARGIN = LENGTH_BITS'(10);

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [CMP_BITS-1:0]      cmp_t;

    typedef enum logic [2:0] {
        TYPE_UNKNOWN = 3'd0,
        TYPE_GIF     = 3'd1,
        TYPE_PNG     = 3'd2,
        TYPE_BMP     = 3'd3,
        TYPE_JPEG    = 3'd4
    } image_type_t;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_SCAN,
        PH_MARKER,
        PH_LENHI,
        PH_LENLO,
        PH_SOF,
        PH_DONE,
        PH_FIXED
    } phase_t;

    localparam logic [7:0] BYTE_MARK = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_PNG0 = 8'd137;

    function automatic logic is_sof(input logic [7:0] code);
        return (code[7:4] == 4'hC) && (code != 8'hC4) && (code != 8'hC8) && (code != 8'hCC);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ihss_if.sv
`default_nettype none
interface ihss_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data_length;

    modport source (output valid, output data_length, input ready);
    modport sink (input valid, input data_length, output ready);
endinterface

interface ihss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihss_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  image_type;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        size_found;

    modport source (output valid, output image_type, output image_width,
                    output image_height, output size_found, input ready);
    modport sink (input valid, input image_type, input image_width,
                  input image_height, input size_found, output ready);
endinterface
`default_nettype wire

FILE: rtl/image_header_size_sniffer.sv
// Takes an image file one byte per word and, after the word marked last, delivers one result
// word with the image type (GIF, PNG, BMP or JPEG), its width and height, and a flag that both
// were found. Load data_length with the file size before streaming; bytes beyond it are ignored.
// The block accepts one byte every cycle: each byte passes through a single compare-and-update
// step against the registered scan state, and the result word appears in an output register
// the cycle after the last byte is accepted. While a result word waits unaccepted, the input
// stalls; a byte is still accepted in the cycle in which the waiting result is taken.
`default_nettype none
module image_header_size_sniffer
    import ihss_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    ihss_cfg_if.sink      cfg,
    ihss_byte_if.sink     data_in,
    ihss_result_if.source result
);

    logic [LENGTH_BITS-1:0] length_reg;
    pos_t        pos_reg, pos_next;
    logic [7:0]  sig_reg [3];
    logic [7:0]  sig_next [3];
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    phase_t      phase_reg, phase_next;
    pos_t        marker_reg, marker_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    image_type_t type_reg, type_next;
    logic [7:0]  prev1_reg, prev1_next, prev2_reg, prev2_next;

    logic        res_valid_reg;
    image_type_t res_type_reg;
    logic [15:0] res_width_reg, res_height_reg;
    logic        res_found_reg;

    logic        accept;
    logic        use_byte;
    logic [7:0]  b;
    logic [LENGTH_BITS-1:0] lim;
    cmp_t        p_ext, lim_ext, tgt;
    pos_t        off;
    phase_t      phase_cur;
    logic        is_gif, is_png, is_bmp;

    assign cfg.ready     = 1'b1;
    assign data_in.ready = !res_valid_reg || result.ready;
    assign accept        = data_in.valid && data_in.ready;
    assign b             = data_in.data_byte;

    always_comb
    begin
        pos_next    = pos_reg;
        sig_next    = sig_reg;
        width_next  = width_reg;
        height_next = height_reg;
        phase_next  = phase_reg;
        marker_next = marker_reg;
        len_hi_next = len_hi_reg;
        type_next   = type_reg;
        prev1_next  = prev1_reg;
        prev2_next  = prev2_reg;

        lim      = (length_reg > LIMIT_MARGIN) ? (length_reg - LIMIT_MARGIN) : length_reg;
        lim_ext  = CMP_BITS'(lim);
        p_ext    = CMP_BITS'(pos_reg);
        use_byte = (p_ext < CMP_BITS'(length_reg)) && (pos_reg != POS_MAX);
        tgt      = CMP_BITS'(marker_reg) + CMP_BITS'({len_hi_reg, b}) + CMP_BITS'(1);
        off      = pos_reg - marker_reg;

        is_gif = (sig_reg[0] == "G") && (sig_reg[1] == "I") && (sig_reg[2] == "F");
        is_png = (sig_reg[0] == BYTE_PNG0) && (sig_reg[1] == "P") && (sig_reg[2] == "N")
                 && (b == "G");
        is_bmp = (sig_reg[1] == "B") && (sig_reg[2] == "M") && (b == "P");

        phase_cur = phase_reg;

        if (use_byte)
        begin
            if (pos_reg == POSITION_BITS'(0)) sig_next[0] = b;
            if (pos_reg == POSITION_BITS'(1)) sig_next[1] = b;
            if (pos_reg == POSITION_BITS'(2)) sig_next[2] = b;

            if ((pos_reg == POSITION_BITS'(3)) && (is_gif || is_png || is_bmp))
            begin
                phase_cur = PH_FIXED;
                if (is_gif)
                    type_next = TYPE_GIF;
                else if (is_png)
                    type_next = TYPE_PNG;
                else
                    type_next = TYPE_BMP;
            end
            phase_next = phase_cur;

            unique case (phase_cur)
                PH_FIXED:
                begin
                    if (type_next == TYPE_GIF)
                    begin
                        if (pos_reg == POSITION_BITS'(6)) width_next[7:0] = b;
                        if (pos_reg == POSITION_BITS'(7)) width_next[15:8] = b;
                        if (pos_reg == POSITION_BITS'(8)) height_next[7:0] = b;
                        if (pos_reg == POSITION_BITS'(9)) height_next[15:8] = b;
                    end
                    else
                    begin
                        if (pos_reg == POSITION_BITS'(18)) width_next[15:8] = b;
                        if (pos_reg == POSITION_BITS'(19)) width_next[7:0] = b;
                        if (pos_reg == POSITION_BITS'(22)) height_next[15:8] = b;
                        if (pos_reg == POSITION_BITS'(23)) height_next[7:0] = b;
                    end
                end
                PH_SEARCH:
                begin
                    if ((p_ext >= CMP_BITS'(2)) && ((p_ext - CMP_BITS'(2)) < lim_ext)
                        && (prev2_reg == BYTE_MARK) && (prev1_reg == BYTE_SOI)
                        && (b == BYTE_MARK))
                        phase_next = PH_MARKER;
                end
                PH_SCAN:
                begin
                    if (pos_reg >= marker_reg)
                    begin
                        if (b == BYTE_MARK)
                            phase_next = PH_MARKER;
                        else if (p_ext >= lim_ext)
                            phase_next = PH_DONE;
                    end
                end
                PH_MARKER:
                begin
                    marker_next = pos_reg;
                    if (is_sof(b))
                    begin
                        type_next   = TYPE_JPEG;
                        width_next  = '0;
                        height_next = '0;
                        phase_next  = PH_SOF;
                    end
                    else
                    begin
                        phase_next = PH_LENHI;
                    end
                end
                PH_LENHI:
                begin
                    len_hi_next = b;
                    phase_next  = PH_LENLO;
                end
                PH_LENLO:
                begin
                    if (tgt >= lim_ext)
                        phase_next = PH_DONE;
                    else if (tgt <= p_ext)
                    begin
                        if (p_ext >= lim_ext)
                            phase_next = PH_DONE;
                        else
                        begin
                            marker_next = pos_reg + POSITION_BITS'(1);
                            phase_next  = PH_SCAN;
                        end
                    end
                    else
                    begin
                        marker_next = tgt[POSITION_BITS-1:0];
                        phase_next  = PH_SCAN;
                    end
                end
                PH_SOF:
                begin
                    if (off == POSITION_BITS'(4)) height_next[15:8] = b;
                    if (off == POSITION_BITS'(5)) height_next[7:0] = b;
                    if (off == POSITION_BITS'(6)) width_next[15:8] = b;
                    if (off == POSITION_BITS'(7))
                    begin
                        width_next[7:0] = b;
                        phase_next      = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase

            prev2_next = prev1_reg;
            prev1_next = b;
        end

        if (pos_reg != POS_MAX)
            pos_next = pos_reg + POSITION_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            length_reg <= cfg.data_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sig_reg    <= '{default: '0};
            width_reg  <= '0;
            height_reg <= '0;
            phase_reg  <= PH_SEARCH;
            marker_reg <= '0;
            len_hi_reg <= '0;
            type_reg   <= TYPE_UNKNOWN;
            prev1_reg  <= '0;
            prev2_reg  <= '0;
        end
        else if (accept)
        begin
            if (data_in.last_byte)
            begin
                pos_reg    <= '0;
                sig_reg    <= '{default: '0};
                width_reg  <= '0;
                height_reg <= '0;
                phase_reg  <= PH_SEARCH;
                marker_reg <= '0;
                len_hi_reg <= '0;
                type_reg   <= TYPE_UNKNOWN;
                prev1_reg  <= '0;
                prev2_reg  <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                sig_reg    <= sig_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                phase_reg  <= phase_next;
                marker_reg <= marker_next;
                len_hi_reg <= len_hi_next;
                type_reg   <= type_next;
                prev1_reg  <= prev1_next;
                prev2_reg  <= prev2_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            res_type_reg   <= TYPE_UNKNOWN;
            res_width_reg  <= '0;
            res_height_reg <= '0;
            res_found_reg  <= 1'b0;
        end
        else if (accept && data_in.last_byte)
        begin
            res_valid_reg  <= 1'b1;
            res_type_reg   <= type_next;
            res_width_reg  <= width_next;
            res_height_reg <= height_next;
            res_found_reg  <= (width_next != 16'd0) && (height_next != 16'd0);
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.image_type   = res_type_reg;
    assign result.image_width  = res_width_reg;
    assign result.image_height = res_height_reg;
    assign result.size_found   = res_found_reg;

endmodule
`default_nettype wire

FILE: test/image_header_size_sniffer_tb.sv
`default_nettype none
module image_header_size_sniffer_tb;
    import ihss_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int BREAK_PERCENT = 12;
    localparam int CALM_FIRST = 600;
    localparam int CALM_LAST = 1000;
    localparam logic [7:0] SOF_LOW = 8'hC0;
    localparam logic [7:0] SOF_HIGH = 8'hCF;
    localparam logic [7:0] MARK_DHT = 8'hC4;
    localparam logic [7:0] MARK_JPG = 8'hC8;
    localparam logic [7:0] MARK_DAC = 8'hCC;
    localparam logic [23:0] LENGTH_MAX = 24'hFFFFFF;

    typedef enum int {FORM_GIF, FORM_PNG, FORM_BMP, FORM_JPEG, FORM_NOISE} file_form_t;

    typedef struct {
        image_type_t kind;
        logic [15:0] width;
        logic [15:0] height;
        logic        found;
    } size_report_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } byte_word_t;

    logic clk = 1'b0;
    logic rst_n;

    ihss_cfg_if cfg_bus();
    ihss_byte_if byte_bus();
    ihss_result_if size_bus();

    image_header_size_sniffer uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_bus),
        .data_in(byte_bus),
        .result(size_bus)
    );

    always #5 clk = ~clk;

    logic [23:0] length_reg;
    pos_t        byte_pos;
    logic [7:0]  sig [4];
    logic [15:0] got_w;
    logic [15:0] got_h;
    phase_t      scan_ph;
    pos_t        mark_pos;
    logic [7:0]  seg_hi;
    image_type_t kind;
    logic [7:0]  back1;
    logic [7:0]  back2;

    byte_word_t   bytes_waiting[$];
    size_report_t reports_due[$];
    logic [7:0]   file_bytes[$];

    int errors = 0;
    int quiet_cycles = 0;
    int cycle_no = 0;
    int calm_left = 0;

    function automatic logic is_frame_start(input logic [7:0] code);
        return code >= SOF_LOW && code <= SOF_HIGH && code != MARK_DHT && code != MARK_JPG
               && code != MARK_DAC;
    endfunction

    function automatic void restart_scan();
        byte_pos = '0;
        for (int i = 0; i < 4; i++)
            sig[i] = 8'h00;
        got_w = '0;
        got_h = '0;
        scan_ph = PH_SEARCH;
        mark_pos = '0;
        seg_hi = '0;
        kind = TYPE_UNKNOWN;
        back1 = '0;
        back2 = '0;
    endfunction

    task automatic sniff_byte(input logic [7:0] b, input logic last);
        pos_t p;
        longint unsigned lim;
        longint unsigned seg_len;
        longint unsigned target;
        size_report_t report;
        p = byte_pos;
        if (p < length_reg && p != POS_MAX)
        begin
            lim = (length_reg > 10) ? length_reg - 10 : length_reg;
            if (p < 4)
                sig[p[1:0]] = b;
            if (p == 3)
            begin
                if (sig[0] == "G" && sig[1] == "I" && sig[2] == "F")
                begin
                    kind = TYPE_GIF;
                    scan_ph = PH_FIXED;
                end
                else if (sig[0] == BYTE_PNG0 && sig[1] == "P" && sig[2] == "N" && sig[3] == "G")
                begin
                    kind = TYPE_PNG;
                    scan_ph = PH_FIXED;
                end
                else if (sig[1] == "B" && sig[2] == "M" && sig[3] == "P")
                begin
                    kind = TYPE_BMP;
                    scan_ph = PH_FIXED;
                end
            end
            case (scan_ph)
                PH_FIXED:
                begin
                    if (kind == TYPE_GIF)
                    begin
                        case (p)
                            6: got_w[7:0] = b;
                            7: got_w[15:8] = b;
                            8: got_h[7:0] = b;
                            9: got_h[15:8] = b;
                            default: ;
                        endcase
                    end
                    else
                    begin
                        case (p)
                            18: got_w[15:8] = b;
                            19: got_w[7:0] = b;
                            22: got_h[15:8] = b;
                            23: got_h[7:0] = b;
                            default: ;
                        endcase
                    end
                end
                PH_SEARCH:
                begin
                    if (p >= 2 && p - 2 < lim && back2 == BYTE_MARK && back1 == BYTE_SOI
                        && b == BYTE_MARK)
                        scan_ph = PH_MARKER;
                end
                PH_SCAN:
                begin
                    if (p >= mark_pos)
                    begin
                        if (b == BYTE_MARK)
                            scan_ph = PH_MARKER;
                        else if (p >= lim)
                            scan_ph = PH_DONE;
                    end
                end
                PH_MARKER:
                begin
                    mark_pos = p;
                    if (is_frame_start(b))
                    begin
                        kind = TYPE_JPEG;
                        got_w = '0;
                        got_h = '0;
                        scan_ph = PH_SOF;
                    end
                    else
                        scan_ph = PH_LENHI;
                end
                PH_LENHI:
                begin
                    seg_hi = b;
                    scan_ph = PH_LENLO;
                end
                PH_LENLO:
                begin
                    seg_len = {seg_hi, b};
                    target = longint'(mark_pos) + seg_len + 1;
                    if (target >= lim)
                        scan_ph = PH_DONE;
                    else if (target <= p)
                    begin
                        if (p >= lim)
                            scan_ph = PH_DONE;
                        else
                        begin
                            mark_pos = p + pos_t'(1);
                            scan_ph = PH_SCAN;
                        end
                    end
                    else
                    begin
                        mark_pos = pos_t'(target);
                        scan_ph = PH_SCAN;
                    end
                end
                PH_SOF:
                begin
                    case (p - mark_pos)
                        4: got_h[15:8] = b;
                        5: got_h[7:0] = b;
                        6: got_w[15:8] = b;
                        7:
                        begin
                            got_w[7:0] = b;
                            scan_ph = PH_DONE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            back2 = back1;
            back1 = b;
        end
        if (byte_pos != POS_MAX)
            byte_pos = byte_pos + pos_t'(1);
        if (last)
        begin
            report.kind = kind;
            report.width = got_w;
            report.height = got_h;
            report.found = (got_w != 0 && got_h != 0);
            reports_due.push_back(report);
            restart_scan();
        end
    endtask

    function automatic logic take_break();
        if (calm_left != 0 || (cycle_no >= CALM_FIRST && cycle_no < CALM_LAST))
            return 1'b0;
        return $urandom_range(0, 99) < BREAK_PERCENT;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        byte_word_t word;
        if (!rst_n)
        begin
            byte_bus.valid <= 1'b0;
            byte_bus.data_byte <= '0;
            byte_bus.last_byte <= 1'b0;
            length_reg = '0;
            restart_scan();
        end
        else
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                length_reg = cfg_bus.data_length;
            if (byte_bus.valid && byte_bus.ready)
                sniff_byte(byte_bus.data_byte, byte_bus.last_byte);
            if (!byte_bus.valid || byte_bus.ready)
            begin
                if (bytes_waiting.size() != 0 && !take_break())
                begin
                    word = bytes_waiting.pop_front();
                    byte_bus.valid <= 1'b1;
                    byte_bus.data_byte <= word.value;
                    byte_bus.last_byte <= word.last;
                end
                else
                    byte_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : size_monitor
        size_report_t want;
        if (!rst_n)
            size_bus.ready <= 1'b0;
        else
        begin
            if (size_bus.valid && size_bus.ready)
            begin
                if (reports_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, actual type %0d %0dx%0d",
                             $time, size_bus.image_type, size_bus.image_width,
                             size_bus.image_height);
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("image_type", 16'(want.kind), 16'(size_bus.image_type));
                    check_field("image_width", want.width, size_bus.image_width);
                    check_field("image_height", want.height, size_bus.image_height);
                    check_field("size_found", 16'(want.found), 16'(size_bus.size_found));
                end
            end
            size_bus.ready <= !take_break();
        end
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (calm_left != 0)
            calm_left <= calm_left - 1;
        else if ($urandom_range(0, 799) == 0)
            calm_left <= 300;
        if (!rst_n || (byte_bus.valid && byte_bus.ready) || (size_bus.valid && size_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [7:0] stray_byte();
        case ($urandom_range(0, 7))
            0: return BYTE_MARK;
            1: return 8'h00;
            2: return BYTE_SOI;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (bytes_waiting.size() != 0 || byte_bus.valid || reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_length(input logic [23:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data_length <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic queue_bytes(input int count);
        byte_word_t word;
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            word.value = (i < file_bytes.size()) ? file_bytes[i] : stray_byte();
            word.last = (i == count - 1);
            bytes_waiting.push_back(word);
        end
    endtask

    task automatic make_file(input file_form_t form, input int size);
        logic [7:0]  code;
        logic [15:0] seg_len;
        logic [15:0] dim;
        int          payload;
        file_bytes.delete();
        case (form)
            FORM_GIF: file_bytes = '{"G", "I", "F"};
            FORM_PNG: file_bytes = '{BYTE_PNG0, "P", "N", "G"};
            FORM_BMP: file_bytes = '{stray_byte(), "B", "M", "P"};
            FORM_JPEG:
            begin
                file_bytes = '{BYTE_MARK, BYTE_SOI};
                repeat ($urandom_range(0, 3))
                begin
                    do
                        code = stray_byte();
                    while (is_frame_start(code));
                    case ($urandom_range(0, 9))
                        0: seg_len = 16'($urandom_range(0, 1));
                        1: seg_len = 16'($urandom);
                        default: seg_len = 16'($urandom_range(2, 8));
                    endcase
                    file_bytes.push_back(BYTE_MARK);
                    file_bytes.push_back(code);
                    file_bytes.push_back(seg_len[15:8]);
                    file_bytes.push_back(seg_len[7:0]);
                    payload = (seg_len > 10) ? 8 : int'(seg_len) - 2;
                    repeat (payload) file_bytes.push_back(stray_byte());
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    do
                        code = SOF_LOW | 8'($urandom_range(0, 15));
                    while (!is_frame_start(code));
                    file_bytes.push_back(BYTE_MARK);
                    file_bytes.push_back(code);
                    file_bytes.push_back(8'h00);
                    file_bytes.push_back(8'd17);
                    file_bytes.push_back(8'd8);
                    repeat (2)
                    begin
                        dim = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
                        file_bytes.push_back(dim[15:8]);
                        file_bytes.push_back(dim[7:0]);
                    end
                end
            end
            default: ;
        endcase
        while (file_bytes.size() < size)
            file_bytes.push_back(stray_byte());
    endtask

    initial
    begin : stimulus
        file_form_t  form;
        int          size;
        int          count;
        int          pick;
        int          bytes_queued;
        logic [23:0] length_setting;
        bytes_queued = 0;
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data_length = '0;
        byte_bus.valid = 1'b0;
        byte_bus.data_byte = '0;
        byte_bus.last_byte = 1'b0;
        size_bus.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset length of zero every byte is ignored.
        file_bytes = '{BYTE_MARK, BYTE_SOI, BYTE_MARK};
        queue_bytes(3);
        wait_idle();
        write_length(24'd10);
        file_bytes = '{"G", "I", "F", "8", "9", "a", 8'hFF, 8'hFF, 8'h01, 8'h00};
        queue_bytes(10);
        file_bytes = '{"G"};
        queue_bytes(1);
        wait_idle();
        write_length(24'd11);
        file_bytes = '{BYTE_MARK, BYTE_SOI, BYTE_MARK, SOF_LOW, 8'h00, 8'h11, 8'h08,
                       8'h00, 8'h02, 8'h00, 8'h03};
        queue_bytes(11);

        while (bytes_queued < 1000)
        begin
            form = file_form_t'($urandom_range(0, 4));
            case (form)
                FORM_GIF: size = $urandom_range(4, 24);
                FORM_PNG, FORM_BMP: size = $urandom_range(20, 40);
                FORM_JPEG: size = $urandom_range(20, 72);
                default: size = $urandom_range(1, 40);
            endcase
            pick = $urandom_range(0, 15);
            if (pick == 0)
                length_setting = '0;
            else if (pick == 1)
                length_setting = LENGTH_MAX;
            else if (pick == 2)
                length_setting = 24'($urandom);
            else if (pick <= 4)
                length_setting = 24'(size - $urandom_range(1, size));
            else if (pick == 5)
                length_setting = 24'(size + $urandom_range(1, 12));
            else
                length_setting = 24'(size);
            wait_idle();
            write_length(length_setting);
            repeat ($urandom_range(1, 4))
            begin
                make_file(form, size);
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    count = $urandom_range(1, size);
                else if (pick == 1)
                    count = size + $urandom_range(1, 6);
                else
                    count = size;
                queue_bytes(count);
                bytes_queued += count;
            end
        end

        wait_idle();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: image_header_size_sniffer.f
rtl/ihss_pkg.sv
rtl/ihss_if.sv
rtl/image_header_size_sniffer.sv
test/image_header_size_sniffer_tb.sv
